// ===== hw/rtl/idu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idu_pkg
// Shared types and constants of the integer divide unit: operation modes,
// operation widths and the control and data records that travel down the
// divide pipeline.
// ----------------------------------------------------------------------------
package idu_pkg;

   localparam int OP_WIDTH   = 32;
   localparam int STEP_COUNT = OP_WIDTH;

   typedef enum logic [2:0] {
      MODE_UDIV8  = 3'd0,
      MODE_UDIV16 = 3'd1,
      MODE_UDIV32 = 3'd2,
      MODE_SDIV8  = 3'd3,
      MODE_SDIV16 = 3'd4,
      MODE_SDIV32 = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2
   } width_type;

   typedef struct packed {
      logic      valid;
      logic      sgn;
      width_type width;
      logic      nneg;
      logic      qneg;
      logic      err;
   } ctrl_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] part;
      logic [OP_WIDTH-1:0] bits;
      logic [OP_WIDTH-1:0] dvsr;
   } data_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] quotient;
      logic [OP_WIDTH-1:0] remainder;
      logic                divide_error;
   } res_type;

endpackage
`default_nettype wire

// ===== hw/rtl/idu_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idu_prep
// Entry stage: decode the mode, assemble the dividend and divisor at the
// operation width, take magnitudes of signed operands and flag a zero
// divisor or an unused mode.
// ----------------------------------------------------------------------------
module idu_prep (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               req_valid,
   input  wire logic [2:0]         mode,
   input  wire logic [31:0]        dividend_high,
   input  wire logic [31:0]        dividend_low,
   input  wire logic [31:0]        divisor,
   output idu_pkg::ctrl_type       ctrl_out,
   output idu_pkg::data_type       data_out
);

   idu_pkg::ctrl_type ctrl_in, ctrl_ff;
   idu_pkg::data_type data_in, data_ff;

   always_comb begin
      logic        bad;
      logic [63:0] dvd;
      logic [63:0] dvd_neg;
      logic [63:0] nmag;
      logic [31:0] dv;
      logic [31:0] dv_neg;
      logic        dneg;

      ctrl_in       = '0;
      ctrl_in.valid = req_valid;
      ctrl_in.width = idu_pkg::WIDTH_32;
      bad           = 1'b0;
      unique case (mode)
         idu_pkg::MODE_UDIV8: begin
            ctrl_in.width = idu_pkg::WIDTH_8;
         end
         idu_pkg::MODE_UDIV16: begin
            ctrl_in.width = idu_pkg::WIDTH_16;
         end
         idu_pkg::MODE_UDIV32: begin
            ctrl_in.width = idu_pkg::WIDTH_32;
         end
         idu_pkg::MODE_SDIV8: begin
            ctrl_in.width = idu_pkg::WIDTH_8;
            ctrl_in.sgn   = 1'b1;
         end
         idu_pkg::MODE_SDIV16: begin
            ctrl_in.width = idu_pkg::WIDTH_16;
            ctrl_in.sgn   = 1'b1;
         end
         idu_pkg::MODE_SDIV32: begin
            ctrl_in.width = idu_pkg::WIDTH_32;
            ctrl_in.sgn   = 1'b1;
         end
         default: begin
            bad = 1'b1;
         end
      endcase

      dvd     = {dividend_high, dividend_low};
      dv      = divisor;
      case (ctrl_in.width)
         idu_pkg::WIDTH_8: begin
            dvd = {48'd0, dividend_low[15:0]};
            dv  = {24'd0, divisor[7:0]};
         end
         idu_pkg::WIDTH_16: begin
            dvd = {32'd0, dividend_high[15:0], dividend_low[15:0]};
            dv  = {16'd0, divisor[15:0]};
         end
         default: begin
            dvd = {dividend_high, dividend_low};
            dv  = divisor;
         end
      endcase

      dvd_neg = 64'd0 - dvd;
      dv_neg  = 32'd0 - dv;
      nmag    = dvd;
      case (ctrl_in.width)
         idu_pkg::WIDTH_8: begin
            ctrl_in.nneg = ctrl_in.sgn & dvd[15];
            dneg         = ctrl_in.sgn & dv[7];
            if (ctrl_in.nneg) begin
               nmag = {48'd0, dvd_neg[15:0]};
            end
            if (dneg) begin
               dv = {24'd0, dv_neg[7:0]};
            end
         end
         idu_pkg::WIDTH_16: begin
            ctrl_in.nneg = ctrl_in.sgn & dvd[31];
            dneg         = ctrl_in.sgn & dv[15];
            if (ctrl_in.nneg) begin
               nmag = {32'd0, dvd_neg[31:0]};
            end
            if (dneg) begin
               dv = {16'd0, dv_neg[15:0]};
            end
         end
         default: begin
            ctrl_in.nneg = ctrl_in.sgn & dvd[63];
            dneg         = ctrl_in.sgn & dv[31];
            if (ctrl_in.nneg) begin
               nmag = dvd_neg;
            end
            if (dneg) begin
               dv = dv_neg;
            end
         end
      endcase

      ctrl_in.qneg = ctrl_in.nneg ^ dneg;
      ctrl_in.err  = bad | (divisor == 32'd0) | (dv == 32'd0);
      data_in.part = nmag[63:32];
      data_in.bits = nmag[31:0];
      data_in.dvsr = dv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/idu_range.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idu_range
// Range stage: flag a 32-bit divide whose quotient would need more than
// 32 bits, that is an upper dividend magnitude not below the divisor.
// ----------------------------------------------------------------------------
module idu_range (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  idu_pkg::ctrl_type       up_ctrl,
   input  idu_pkg::data_type       up_data,
   output idu_pkg::ctrl_type       ctrl_out,
   output idu_pkg::data_type       data_out
);

   idu_pkg::ctrl_type ctrl_in, ctrl_ff;
   idu_pkg::data_type data_ff;

   always_comb begin
      ctrl_in     = up_ctrl;
      ctrl_in.err = up_ctrl.err |
                    ((up_ctrl.width == idu_pkg::WIDTH_32) && (up_data.part >= up_data.dvsr));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= up_data;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/idu_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idu_step
// One restoring divide step: shift the next dividend bit into the partial
// remainder, subtract the divisor where it fits and shift in a quotient bit.
// ----------------------------------------------------------------------------
module idu_step (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  idu_pkg::ctrl_type       up_ctrl,
   input  idu_pkg::data_type       up_data,
   output idu_pkg::ctrl_type       ctrl_out,
   output idu_pkg::data_type       data_out
);

   idu_pkg::ctrl_type ctrl_ff;
   idu_pkg::data_type data_in, data_ff;

   always_comb begin
      logic [idu_pkg::OP_WIDTH:0] trial;
      logic [idu_pkg::OP_WIDTH:0] diff;
      logic                       qbit;

      trial = {up_data.part, up_data.bits[idu_pkg::OP_WIDTH-1]};
      diff  = trial - {1'b0, up_data.dvsr};
      qbit  = ~diff[idu_pkg::OP_WIDTH];
      data_in.part = qbit ? diff[idu_pkg::OP_WIDTH-1:0] : trial[idu_pkg::OP_WIDTH-1:0];
      data_in.bits = {up_data.bits[idu_pkg::OP_WIDTH-2:0], qbit};
      data_in.dvsr = up_data.dvsr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (en) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign data_out = data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/idu_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idu_post
// Result stage logic: check the quotient magnitude against the operation
// width, restore signs, mask to width and zero both results on an error.
// ----------------------------------------------------------------------------
module idu_post (
   input  idu_pkg::ctrl_type       ctrl,
   input  idu_pkg::data_type       data,
   output idu_pkg::res_type        res
);

   always_comb begin
      logic [31:0] mask;
      logic [31:0] lim;
      logic [31:0] qval;
      logic [31:0] rval;
      logic        ovf;

      case (ctrl.width)
         idu_pkg::WIDTH_8: begin
            mask = 32'h0000_00ff;
            lim  = 32'h0000_0080;
         end
         idu_pkg::WIDTH_16: begin
            mask = 32'h0000_ffff;
            lim  = 32'h0000_8000;
         end
         default: begin
            mask = 32'hffff_ffff;
            lim  = 32'h8000_0000;
         end
      endcase

      if (!ctrl.sgn) begin
         ovf = (data.bits & ~mask) != 32'd0;
      end else if (ctrl.qneg) begin
         ovf = data.bits > lim;
      end else begin
         ovf = data.bits >= lim;
      end

      qval = ctrl.qneg ? (32'd0 - data.bits) : data.bits;
      rval = ctrl.nneg ? (32'd0 - data.part) : data.part;

      res.divide_error = ctrl.err | ovf;
      res.quotient     = res.divide_error ? 32'd0 : (qval & mask);
      res.remainder    = res.divide_error ? 32'd0 : (rval & mask);
   end

endmodule
`default_nettype wire

// ===== hw/rtl/integer_divide_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_divide_unit
// Pipelined unsigned and signed divide at 8, 16 or 32 bits with divide-error
// detection.
// ----------------------------------------------------------------------------
// The unit takes one divide item every cycle while req_tready is high and
// returns one result per item in order. The operand preparation register
// loads at the accepting edge, followed by one quotient range stage, 32
// restoring divide stages of one quotient bit each, and the output
// register, which raises rsp_tvalid. An output register plus a one-entry
// skid stage keep req_tready high while a finished result waits; the
// pipeline holds only once the skid entry is also occupied.
// ----------------------------------------------------------------------------
module integer_divide_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [95:0]  req_tdata,   // dividend_high, dividend_low, divisor
   input  wire logic [2:0]   req_tuser,   // mode
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [63:0]  rsp_tdata,   // quotient, remainder
   output      logic [0:0]   rsp_tuser    // divide_error
);

   logic pipe_en;

   idu_pkg::ctrl_type prep_ctrl, rng_ctrl;
   idu_pkg::data_type prep_data, rng_data;
   idu_pkg::ctrl_type step_ctrl [0:idu_pkg::STEP_COUNT];
   idu_pkg::data_type step_data [0:idu_pkg::STEP_COUNT];
   idu_pkg::res_type  post_res;

   logic              out_valid_in, out_valid_ff;
   logic              skid_valid_in, skid_valid_ff;
   idu_pkg::res_type  out_res_in, out_res_ff;
   idu_pkg::res_type  skid_res_in, skid_res_ff;

   assign pipe_en    = ~skid_valid_ff;
   assign req_tready = pipe_en;

   idu_prep u_prep (
      .clock         (clock),
      .reset         (reset),
      .en            (pipe_en),
      .req_valid     (req_tvalid),
      .mode          (req_tuser),
      .dividend_high (req_tdata[31:0]),
      .dividend_low  (req_tdata[63:32]),
      .divisor       (req_tdata[95:64]),
      .ctrl_out      (prep_ctrl),
      .data_out      (prep_data)
   );

   idu_range u_range (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .up_ctrl  (prep_ctrl),
      .up_data  (prep_data),
      .ctrl_out (rng_ctrl),
      .data_out (rng_data)
   );

   assign step_ctrl[0] = rng_ctrl;
   assign step_data[0] = rng_data;

   for (genvar i = 0; i < idu_pkg::STEP_COUNT; i++) begin : g_step
      idu_step u_step (
         .clock    (clock),
         .reset    (reset),
         .en       (pipe_en),
         .up_ctrl  (step_ctrl[i]),
         .up_data  (step_data[i]),
         .ctrl_out (step_ctrl[i+1]),
         .data_out (step_data[i+1])
      );
   end

   idu_post u_post (
      .ctrl (step_ctrl[idu_pkg::STEP_COUNT]),
      .data (step_data[idu_pkg::STEP_COUNT]),
      .res  (post_res)
   );

   always_comb begin
      logic move;
      logic take;

      move          = pipe_en & step_ctrl[idu_pkg::STEP_COUNT].valid;
      take          = out_valid_ff & rsp_tready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_res_in    = out_res_ff;
      skid_res_in   = skid_res_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end
      end else if (move) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_res_in   = post_res;
         end else begin
            skid_valid_in = 1'b1;
            skid_res_in   = post_res;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_res_ff.remainder, out_res_ff.quotient};
   assign rsp_tuser[0] = out_res_ff.divide_error;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a pending output item");

   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid entry filled while output was free");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 64'd0))
      else $error("divide error item carries nonzero results");
`endif

endmodule
`default_nettype wire
